// File: design/scf_pkg.sv
// ----------------------------------------------------------------------------
// scf_pkg
// Types and constants shared by the serial command framer modules.
// ----------------------------------------------------------------------------
package scf_pkg;

  localparam logic [7:0] START_CHAR = 8'h21;
  localparam logic [7:0] LF_CHAR    = 8'h0A;
  localparam logic [7:0] CR_CHAR    = 8'h0D;
  localparam logic [7:0] WAIT_MAX   = 8'hFF;

  localparam logic [7:0] CAPACITY_RESET = 8'd64;
  localparam logic [7:0] TIMEOUT_RESET  = 8'd200;

  localparam logic       OP_BYTE = 1'b0;
  localparam logic       OP_TICK = 1'b1;

  localparam logic [1:0] EV_CHAR = 2'd0;
  localparam logic [1:0] EV_DONE = 2'd1;
  localparam logic [1:0] EV_FAIL = 2'd2;

  localparam logic       CFG_CAPACITY = 1'b0;
  localparam logic       CFG_TIMEOUT  = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
    logic       rx_fault;
  } byte_item_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] command_char;
    logic [7:0] command_length;
  } cmd_item_t;

  typedef struct packed {
    logic       in_command;
    logic [7:0] stored_count;
    logic [7:0] wait_count;
  } framer_state_t;

  typedef struct packed {
    logic [7:0] command_capacity;
    logic [7:0] byte_timeout_ticks;
  } framer_cfg_t;

endpackage

// File: design/serial_command_framer_core.sv
// ----------------------------------------------------------------------------
// serial_command_framer_core
// Frames '!'-started, CR/LF-terminated commands from received UART bytes
// and timer ticks.
//
// Input channel byte_*: one item per received byte (opcode 0) or timer
// tick (opcode 1). Output channel cmd_*: command characters, command
// complete with its length, or command failed. Items that cause no event
// (idle bytes, the opening '!', ticks within the timeout) produce nothing.
// Configuration: wr_en/wr_index/wr_data write command_capacity (index 0)
// or byte_timeout_ticks (index 1); write only while the block is idle.
// Data path: an accepted item sits in the input register; its event is
// loaded into the result register once that register is free, and the
// result register drives cmd_valid.
// Throughput: one item per cycle while cmd_stall does not hold the result
// register; set by the single input register and the result register,
// with the framer state updated as an item leaves the input register.
// Reset (rst, synchronous): idle, no command open, capacity 64, timeout
// 200, both channels empty. When cmd_stall holds, the result register
// keeps its event, the input register fills and byte_stall then rises.
// ----------------------------------------------------------------------------
module serial_command_framer_core
  import scf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  byte_item_t byte_item,
  output logic       cmd_valid,
  input  logic       cmd_stall,
  output cmd_item_t  cmd_item,
  input  logic       wr_en,
  input  logic       wr_index,
  input  logic [7:0] wr_data
);

  framer_cfg_t   cfg;
  framer_state_t state;
  framer_state_t state_next;
  byte_item_t    s1_item;
  logic          s1_valid;
  logic          advance;
  logic          emit;
  logic          obuf_free;
  cmd_item_t     result;

  assign advance    = s1_valid && obuf_free;
  assign byte_stall = s1_valid && !obuf_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.command_capacity   <= CAPACITY_RESET;
      cfg.byte_timeout_ticks <= TIMEOUT_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_CAPACITY: cfg.command_capacity   <= wr_data;
        CFG_TIMEOUT:  cfg.byte_timeout_ticks <= wr_data;
        default:      cfg                    <= cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!byte_stall) begin
      s1_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall && byte_valid) begin
      s1_item <= byte_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  scf_step u_step (
    .state      (state),
    .cfg        (cfg),
    .item       (s1_item),
    .state_next (state_next),
    .emit       (emit),
    .result     (result)
  );

  scf_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && emit),
    .load_item (result),
    .free      (obuf_free),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item)
  );

  a_idle_count_clear: assert property (@(posedge clk) disable iff (rst)
    !state.in_command |-> state.stored_count == 8'd0 && state.wait_count == 8'd0)
    else $error("stored or wait count nonzero while idle");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> s1_valid && cmd_valid && cmd_stall)
    else $error("input stalled without a blocked result");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> cmd_item.event_kind == EV_CHAR || cmd_item.event_kind == EV_DONE ||
                  cmd_item.event_kind == EV_FAIL)
    else $error("illegal event kind");

  a_char_only_on_char: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_item.event_kind != EV_CHAR |-> cmd_item.command_char == 8'd0)
    else $error("character set on non-character event");

  a_done_closes: assert property (@(posedge clk) disable iff (rst)
    advance && emit && result.event_kind != EV_CHAR |=> !state.in_command)
    else $error("command still open after complete or fail");

endmodule

// File: design/scf_step.sv
// ----------------------------------------------------------------------------
// scf_step
// Next-state and result logic for one item of the command framer.
// ----------------------------------------------------------------------------
module scf_step
  import scf_pkg::*;
(
  input  framer_state_t state,
  input  framer_cfg_t   cfg,
  input  byte_item_t    item,
  output framer_state_t state_next,
  output logic          emit,
  output cmd_item_t     result
);

  logic [7:0] wait_inc;
  logic       is_eol;
  logic       timed_out;

  assign wait_inc  = (state.wait_count < WAIT_MAX) ? state.wait_count + 8'd1
                                                   : state.wait_count;
  assign is_eol    = (item.rx_byte == CR_CHAR) || (item.rx_byte == LF_CHAR);
  assign timed_out = (cfg.byte_timeout_ticks != 8'd0) &&
                     (wait_inc > cfg.byte_timeout_ticks);

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    result     = '0;
    if (!state.in_command) begin
      if (item.opcode == OP_BYTE && !item.rx_fault && item.rx_byte == START_CHAR) begin
        state_next.in_command   = 1'b1;
        state_next.stored_count = 8'd0;
        state_next.wait_count   = 8'd0;
      end
    end else if (item.opcode == OP_TICK) begin
      state_next.wait_count = wait_inc;
      if (timed_out) begin
        state_next        = '0;
        emit              = 1'b1;
        result.event_kind = EV_FAIL;
      end
    end else begin
      state_next.wait_count = 8'd0;
      priority if (item.rx_fault || state.stored_count >= cfg.command_capacity) begin
        state_next        = '0;
        emit              = 1'b1;
        result.event_kind = EV_FAIL;
      end else if (is_eol) begin
        state_next            = '0;
        emit                  = 1'b1;
        result.event_kind     = EV_DONE;
        result.command_length = state.stored_count;
      end else begin
        state_next.stored_count = state.stored_count + 8'd1;
        emit                    = 1'b1;
        result.event_kind       = EV_CHAR;
        result.command_char     = item.rx_byte;
      end
    end
  end

endmodule

// File: design/scf_obuf.sv
// ----------------------------------------------------------------------------
// scf_obuf
// Result register for the command framer output channel.
// ----------------------------------------------------------------------------
module scf_obuf
  import scf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  cmd_item_t load_item,
  output logic      free,
  output logic      cmd_valid,
  input  logic      cmd_stall,
  output cmd_item_t cmd_item
);

  assign free = !cmd_valid || !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (free) begin
      cmd_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      cmd_item <= load_item;
    end
  end

endmodule
